// ----- design/hbk_pkg.sv -----
// Shared types, constants and the key usage lookup for the boot keyboard decoder.
package hbk_pkg;

  localparam int unsigned KeySlots = 6;
  localparam int unsigned CodeW    = 8;
  localparam int unsigned CharW    = 7;
  localparam int unsigned IdxW     = (KeySlots > 1) ? $clog2(KeySlots) : 1;

  localparam logic [CodeW-1:0] ShiftMask = 8'h22;

  typedef logic [CodeW-1:0] code_t;
  typedef logic [CharW-1:0] char_t;

  // What one lane reports for its slot
  typedef struct packed {
    logic  hit;
    char_t ch;
  } lane_res_t;

  // Usage code to ASCII; zero means the code has no character
  function automatic char_t usage_to_ascii(code_t code, logic shift);
    char_t c;
    code_t off;
    c   = '0;
    off = '0;
    if (code >= 8'h04 && code <= 8'h1D) begin
      // letters, upper case under shift
      off = code - 8'h04;
      c   = shift ? (7'h41 + off[CharW-1:0]) : (7'h61 + off[CharW-1:0]);
    end else if (code >= 8'h1E && code <= 8'h26) begin
      // digits one to nine
      off = code - 8'h1E;
      c   = 7'h31 + off[CharW-1:0];
    end else begin
      case (code)
        8'h27:   c = 7'h30;  // 0
        8'h28:   c = 7'h0A;  // enter
        8'h2A:   c = 7'h08;  // backspace
        8'h2B:   c = 7'h09;  // tab
        8'h2C:   c = 7'h20;  // space
        8'h2D:   c = 7'h2D;  // -
        8'h2E:   c = 7'h3D;  // =
        8'h2F:   c = 7'h5B;  // [
        8'h30:   c = 7'h5D;  // ]
        8'h31:   c = 7'h5C;  // backslash
        8'h32:   c = 7'h23;  // #
        8'h33:   c = 7'h3B;  // ;
        8'h34:   c = 7'h27;  // quote
        8'h35:   c = 7'h60;  // grave
        8'h36:   c = 7'h2C;  // ,
        8'h37:   c = 7'h2E;  // .
        8'h38:   c = 7'h2F;  // /
        default: c = '0;
      endcase
    end
    return c;
  endfunction

endpackage

// ----- design/hbk_lane.sv -----
// One slot lane: checks the code against the held keys and looks up its character.
module hbk_lane (
  input  hbk_pkg::code_t                        code_i,
  input  hbk_pkg::code_t [hbk_pkg::KeySlots-1:0] held_i,
  input  logic                                  shift_i,
  output hbk_pkg::lane_res_t                    res_o
);
  import hbk_pkg::*;

  logic  was_held;
  char_t ch;

  // compare against every held code
  always_comb begin
    was_held = 1'b0;
    for (int i = 0; i < KeySlots; i++) begin
      if (held_i[i] == code_i) was_held = 1'b1;
    end
  end

  assign ch        = usage_to_ascii(code_i, shift_i);
  assign res_o.ch  = ch;
  assign res_o.hit = (code_i != '0) && !was_held && (ch != '0);

endmodule

// ----- design/hbk_merge.sv -----
// Merging stage: holds one report's lane results and sends its characters out in slot order.
module hbk_merge (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      load_i,
  input  hbk_pkg::lane_res_t [hbk_pkg::KeySlots-1:0] res_i,
  output logic                                      ready_o,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output hbk_pkg::char_t                            ascii_char_o,
  output logic                                      last_o
);
  import hbk_pkg::*;

  logic [KeySlots-1:0] mask_q, mask_d, rest;
  char_t               char_q [KeySlots];
  logic                out_valid_q;
  char_t               out_char_q;
  logic                out_last_q;
  logic                take;
  logic [IdxW-1:0]     sel;

  // output register free this cycle
  assign take = !out_valid_q || out_ready_i;
  // pending slots once the lowest one has gone
  assign rest = mask_q & (mask_q - 1'b1);
  // a new request fits when the pending set empties this cycle
  assign ready_o = (mask_q == '0) || (take && (rest == '0));

  // lowest pending slot
  always_comb begin
    sel = '0;
    for (int i = KeySlots - 1; i >= 0; i--) begin
      if (mask_q[i]) sel = IdxW'(i);
    end
  end

  always_comb begin
    mask_d = take ? rest : mask_q;
    if (load_i) begin
      for (int i = 0; i < KeySlots; i++) mask_d[i] = res_i[i].hit;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q <= mask_d;
      if (take) out_valid_q <= |mask_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int i = 0; i < KeySlots; i++) char_q[i] <= res_i[i].ch;
    end
    if (take && (|mask_q)) begin
      out_char_q <= char_q[sel];
      out_last_q <= (rest == '0);
    end
  end

  assign out_valid_o  = out_valid_q;
  assign ascii_char_o = out_char_q;
  assign last_o       = out_last_q;

endmodule

// ----- design/hid_boot_keyboard_to_ascii_core.sv -----
// Boot keyboard report decoder: six slot lanes, held-key register and output merge.
// Each character is registered in the pending slots, then in the output register.
// Throughput: one character per cycle while out_ready_i is high; the single output
// register drains pending slots in order; a new report fits as the last one drains.
// Reset (rst_ni low, asynchronous): no keys held, nothing pending, output not valid.
module hid_boot_keyboard_to_ascii_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            modifier_bits_i,
  input  hbk_pkg::code_t        key_slot_0_i,
  input  hbk_pkg::code_t        key_slot_1_i,
  input  hbk_pkg::code_t        key_slot_2_i,
  input  hbk_pkg::code_t        key_slot_3_i,
  input  hbk_pkg::code_t        key_slot_4_i,
  input  hbk_pkg::code_t        key_slot_5_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output hbk_pkg::char_t        ascii_char_o,
  output logic                  last_of_report_o
);
  import hbk_pkg::*;

  code_t [KeySlots-1:0]     now_codes;
  code_t [KeySlots-1:0]     held_q;
  lane_res_t [KeySlots-1:0] lane_res;
  logic                     shift;
  logic                     accept;

  assign now_codes = {key_slot_5_i, key_slot_4_i, key_slot_3_i,
                      key_slot_2_i, key_slot_1_i, key_slot_0_i};
  assign shift  = (modifier_bits_i & ShiftMask) != '0;
  assign accept = in_valid_i && in_ready_o;

  // held keys follow each accepted report
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
    end else if (accept) begin
      held_q <= now_codes;
    end
  end

  // one lane per key slot
  for (genvar g = 0; g < KeySlots; g++) begin : g_lane
    hbk_lane u_lane (
      .code_i  (now_codes[g]),
      .held_i  (held_q),
      .shift_i (shift),
      .res_o   (lane_res[g])
    );
  end

  hbk_merge u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .res_i        (lane_res),
    .ready_o      (in_ready_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .ascii_char_o (ascii_char_o),
    .last_o       (last_of_report_o)
  );

endmodule

// ----- tb/tb_hid_boot_keyboard_to_ascii_core.sv -----
// Self-checking bench for the boot keyboard report decoder, with a scoreboard of expected characters.
module tb_hid_boot_keyboard_to_ascii_core;
  import hbk_pkg::*;

  localparam int HoldCycles  = 200;  // long receiver hold-off
  localparam int TailCycles  = 16;   // settle time once nothing is expected
  localparam int RandReports = 210;

  typedef logic [KeySlots-1:0][CodeW-1:0] report_keys_t;

  typedef struct packed {
    char_t ch;
    logic  last;
  } typed_char_t;

  // Expected characters and the held-key state that produces them
  class ascii_scoreboard;
    code_t       held_codes[KeySlots];
    typed_char_t expected_chars[$];
    int          mismatches;

    function new();
      foreach (held_codes[i]) held_codes[i] = '0;
      mismatches = 0;
    endfunction

    // Usage code to ASCII, zero where the code has no character
    function automatic char_t usage_char(code_t code, logic shifted);
      logic [7:0] c;
      c = 8'h00;
      if (code >= 8'h04 && code <= 8'h1D)
        c = (shifted ? 8'h41 : 8'h61) + (code - 8'h04);
      else if (code >= 8'h1E && code <= 8'h26)
        c = 8'h31 + (code - 8'h1E);
      else begin
        case (code)
          8'h27: c = 8'h30;  // 0
          8'h28: c = 8'h0A;  // enter
          8'h2A: c = 8'h08;  // backspace
          8'h2B: c = 8'h09;  // tab
          8'h2C: c = 8'h20;  // space
          8'h2D: c = 8'h2D;  // minus
          8'h2E: c = 8'h3D;  // equals
          8'h2F: c = 8'h5B;  // open bracket
          8'h30: c = 8'h5D;  // close bracket
          8'h31: c = 8'h5C;  // backslash
          8'h32: c = 8'h23;  // hash
          8'h33: c = 8'h3B;  // semicolon
          8'h34: c = 8'h27;  // apostrophe
          8'h35: c = 8'h60;  // grave
          8'h36: c = 8'h2C;  // comma
          8'h37: c = 8'h2E;  // full stop
          8'h38: c = 8'h2F;  // slash
          default: c = 8'h00;
        endcase
      end
      return c[CharW-1:0];
    endfunction

    // Work out the characters one accepted request causes
    function void predict_report(logic [7:0] mods, report_keys_t keys);
      typed_char_t fresh[$];
      typed_char_t item;
      logic        shifted;
      logic        seen;
      char_t       c;
      shifted = (mods & ShiftMask) != 0;
      for (int s = 0; s < KeySlots; s++) begin
        seen = 1'b0;
        foreach (held_codes[h]) if (held_codes[h] == keys[s]) seen = 1'b1;
        c = usage_char(keys[s], shifted);
        if (keys[s] != 0 && !seen && c != 0) begin
          item.ch   = c;
          item.last = 1'b0;
          fresh.push_back(item);
        end
      end
      if (fresh.size() > 0) fresh[fresh.size()-1].last = 1'b1;
      foreach (fresh[i]) expected_chars.push_back(fresh[i]);
      for (int s = 0; s < KeySlots; s++) held_codes[s] = keys[s];
    endfunction

    // Compare one delivered character with the oldest expectation
    function void check_char(char_t ch, logic last);
      typed_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, ch, last);
        mismatches++;
        return;
      end
      want = expected_chars.pop_front();
      if (want.ch !== ch) begin
        $display("%0t: ascii_char expected %h actual %h", $time, want.ch, ch);
        mismatches++;
      end
      if (want.last !== last) begin
        $display("%0t: last_of_report expected %b actual %b", $time, want.last, last);
        mismatches++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] modifier_bits_i;
  code_t      key_slot_0_i, key_slot_1_i, key_slot_2_i;
  code_t      key_slot_3_i, key_slot_4_i, key_slot_5_i;
  logic       out_valid_o;
  logic       out_ready_i;
  char_t      ascii_char_o;
  logic       last_of_report_o;

  bit steady_flow;   // no idling on either side
  bit hold_off_req;  // ask the receiver for a long hold-off

  ascii_scoreboard board = new();

  hid_boot_keyboard_to_ascii_core u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .modifier_bits_i  (modifier_bits_i),
    .key_slot_0_i     (key_slot_0_i),
    .key_slot_1_i     (key_slot_1_i),
    .key_slot_2_i     (key_slot_2_i),
    .key_slot_3_i     (key_slot_3_i),
    .key_slot_4_i     (key_slot_4_i),
    .key_slot_5_i     (key_slot_5_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .ascii_char_o     (ascii_char_o),
    .last_of_report_o (last_of_report_o)
  );

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Run limit
  initial begin
    #3_000_000;
    $display("** hid_boot_keyboard_to_ascii_core: FAILED **");
    $finish;
  end

  // Receiver: random ready, with a counted hold-off on request
  initial begin
    int hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        hold_left    = HoldCycles;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_ready_i <= 1'b0;
        hold_left--;
      end else if (steady_flow) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 36);
      end
    end
  end

  // Result monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) board.check_char(ascii_char_o, last_of_report_o);
  end

  function automatic report_keys_t keys6(code_t a, code_t b, code_t c,
                                         code_t d, code_t e, code_t f);
    report_keys_t k;
    k[0] = a; k[1] = b; k[2] = c; k[3] = d; k[4] = e; k[5] = f;
    return k;
  endfunction

  // Offer one request, idling first at random, and note it once taken
  task automatic send_report(input logic [7:0] mods, input report_keys_t keys);
    while (!steady_flow && $urandom_range(99) < 36) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i      <= 1'b1;
    modifier_bits_i <= mods;
    key_slot_0_i    <= keys[0];
    key_slot_1_i    <= keys[1];
    key_slot_2_i    <= keys[2];
    key_slot_3_i    <= keys[3];
    key_slot_4_i    <= keys[4];
    key_slot_5_i    <= keys[5];
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    board.predict_report(mods, keys);
  endtask

  // Stop sending until every expected character has come out
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
  endtask

  // Stimulus
  initial begin
    report_keys_t typing;
    report_keys_t keys;
    logic [7:0]   mods;
    int           pick;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    modifier_bits_i = '0;
    key_slot_0_i    = '0;
    key_slot_1_i    = '0;
    key_slot_2_i    = '0;
    key_slot_3_i    = '0;
    key_slot_4_i    = '0;
    key_slot_5_i    = '0;
    steady_flow     = 1'b0;
    hold_off_req    = 1'b0;
    typing          = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty report, letters, repeat with nothing new, release
    send_report(8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'h00, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(8'h22, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
    send_report(8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // shift on letters and on non-letters, each shift bit alone, other modifiers without shift, and both
    send_report(8'h02, keys6(8'h1D, 8'h1E, 8'h28, 8'h2C, 8'h38, 8'h2A));
    send_report(8'h20, keys6(8'h0A, 8'h0B, 8'h2B, 8'h27, 8'h26, 8'h2D));
    send_report(8'hDD, keys6(8'h14, 8'h15, 8'h16, 8'h17, 8'h18, 8'h19));
    send_report(8'hFF, keys6(8'h2E, 8'h2F, 8'h30, 8'h31, 8'h32, 8'h33));
    // unmapped codes give nothing but are still held
    send_report(8'h00, keys6(8'h01, 8'h02, 8'h03, 8'h29, 8'h39, 8'hFF));
    send_report(8'h00, keys6(8'h29, 8'h39, 8'h04, 8'h00, 8'hFF, 8'h80));
    send_report(8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    // one new code in every slot, then the same again
    send_report(8'h00, keys6(8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05));
    send_report(8'h00, keys6(8'h05, 8'h05, 8'h05, 8'h05, 8'h05, 8'h05));
    send_report(8'h02, keys6(8'h05, 8'h34, 8'h35, 8'h36, 8'h37, 8'h1C));
    send_report(8'h22, keys6(8'h1A, 8'h1B, 8'h7F, 8'h40, 8'h00, 8'h38));
    send_report(8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
    send_report(8'h00, keys6(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1D));
    send_report(8'h02, keys6(8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1D));
    send_report(8'h00, keys6(8'h1F, 8'h20, 8'h21, 8'h22, 8'h23, 8'h24));
    send_report(8'h00, keys6(8'h25, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));

    // Back-pressure: receiver holds off while full reports keep coming
    wait_drained();
    steady_flow  = 1'b1;
    hold_off_req = 1'b1;
    for (int i = 0; i < 20; i++) begin
      if (i % 2 == 0) send_report(8'h00, keys6(8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09));
      else            send_report(8'h20, keys6(8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h0E, 8'h0F));
    end
    steady_flow = 1'b0;
    wait_drained();

    // Random: mostly evolving typing, some raw noise
    for (int i = 0; i < RandReports; i++) begin
      if (i == 80)  steady_flow = 1'b1;
      if (i == 140) steady_flow = 1'b0;
      if (i == 190) wait_drained();
      if ($urandom_range(99) < 20) begin
        mods = 8'($urandom);
        for (int s = 0; s < KeySlots; s++) keys[s] = code_t'($urandom);
      end else begin
        for (int s = 0; s < KeySlots; s++) begin
          if ($urandom_range(99) < 35) begin
            pick = $urandom_range(99);
            if (pick < 30)      typing[s] = 8'h00;
            else if (pick < 90) typing[s] = code_t'($urandom_range(8'h38, 8'h04));
            else                typing[s] = code_t'($urandom_range(255, 1));
          end
        end
        case ($urandom_range(3))
          0:       mods = 8'h00;
          1:       mods = 8'h02;
          2:       mods = 8'h20;
          default: mods = 8'($urandom);
        endcase
        keys = typing;
      end
      send_report(mods, keys);
    end

    // Drain and settle
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    if (board.pending() != 0)
      $display("%0t: %0d expected characters never arrived", $time, board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("** hid_boot_keyboard_to_ascii_core: PASSED **");
    end else begin
      $display("** hid_boot_keyboard_to_ascii_core: FAILED **");
    end
    $finish;
  end

endmodule
